### hdl/btf_pkg.sv
package btf_pkg;

   // Contrast scale top; the stored duty is this value minus the request.
   localparam int unsigned CONTRAST_TOP = 255;
   localparam int unsigned CONTRAST_REQ_RESET = 59;
   localparam logic [7:0] CONTRAST_RESET =
      8'((CONTRAST_REQ_RESET < CONTRAST_TOP) ? (CONTRAST_TOP - CONTRAST_REQ_RESET) : 0);

   // Levels are held as a code: level plus one, so code zero is off.
   localparam logic [4:0] LEVEL_MAX  = 5'd16;
   localparam logic [4:0] CODE_OFF   = 5'd0;
   localparam logic [4:0] CODE_FOUR  = 5'd5;

   // Register reset values.
   localparam logic [4:0] BRIGHT_RESET    = 5'd14;
   localparam logic [4:0] DIM_RESET       = 5'd7;
   localparam logic [7:0] TIMEOUT_RESET   = 8'd30;
   localparam logic [9:0] THRESHOLD_RESET = 10'd700;
   localparam logic [4:0] LEVEL_CODE_RESET = 5'd15;

   // Register indexes of the configuration port.
   localparam int unsigned REG_INDEX_W = 3;
   localparam int unsigned REG_DATA_W  = 10;
   localparam logic [REG_INDEX_W-1:0] REG_BRIGHT    = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_DIM       = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_TIMEOUT   = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_LOCK      = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_CONTRAST  = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD = 3'd5;

   // Hold times in milliseconds.
   localparam logic [5:0] HOLD_NONE = 6'd0;
   localparam logic [5:0] HOLD_HALF = 6'd25;
   localparam logic [5:0] HOLD_FULL = 6'd50;

   // Command passed from the front to the back.
   typedef struct packed {
      logic [4:0] target;
      logic       lock;
      logic [7:0] contrast;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic [7:0] backlight_duty;
      logic       backlight_enable;
      logic       display_on;
      logic [7:0] contrast_duty;
      logic [5:0] hold_ms;
      logic       still_fading;
      logic       last;
   } rsp_type;

   // Duty of a level code; off reads as zero.
   function automatic logic [7:0] level_duty(input logic [4:0] code);
      logic [7:0] d;
      unique case (code)
         5'd0:  d = 8'd0;
         5'd1:  d = 8'd0;
         5'd2:  d = 8'd1;
         5'd3:  d = 8'd2;
         5'd4:  d = 8'd3;
         5'd5:  d = 8'd4;
         5'd6:  d = 8'd8;
         5'd7:  d = 8'd13;
         5'd8:  d = 8'd21;
         5'd9:  d = 8'd32;
         5'd10: d = 8'd45;
         5'd11: d = 8'd62;
         5'd12: d = 8'd83;
         5'd13: d = 8'd108;
         5'd14: d = 8'd137;
         5'd15: d = 8'd171;
         5'd16: d = 8'd210;
         default: d = 8'd255;
      endcase
      return d;
   endfunction

   // Duty halfway between a level and the one below it.
   function automatic logic [7:0] half_duty(input logic [4:0] code);
      logic [7:0] hi;
      logic [7:0] lo;
      hi = level_duty(code);
      lo = level_duty(code - 5'd1);
      return 8'(((hi - lo) >> 1) + lo);
   endfunction

endpackage

### hdl/backlight_timeout_fader.sv
// Channel   Handshake              Payload
// req       push / full            cmd, now_seconds, second_pulse, supply_sample,
//                                  relay_auto_on
// rsp       empty / pop            backlight_duty, backlight_enable, display_on,
//                                  contrast_duty, hold_ms, still_fading, last
// csr       valid / ready          index (3 bits), data (10 bits)
//
// An item yields one result in the back end, two for a fall above level four;
// the back end writes one result per cycle into its result queue while it has space.
// Reset is synchronous; both two-entry queues come up empty and all control
// registers take their reset values at once; queue payload storage is not reset.
// The front stalls only when the command queue is full, the back only when
// the result queue is full and no item is being popped.
module backlight_timeout_fader (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic                                req_cmd,
   input  logic [31:0]                         req_now_seconds,
   input  logic                                req_second_pulse,
   input  logic [9:0]                          req_supply_sample,
   input  logic                                req_relay_auto_on,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [7:0]                          rsp_backlight_duty,
   output logic                                rsp_backlight_enable,
   output logic                                rsp_display_on,
   output logic [7:0]                          rsp_contrast_duty,
   output logic [5:0]                          rsp_hold_ms,
   output logic                                rsp_still_fading,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [btf_pkg::REG_INDEX_W-1:0]     csr_index,
   input  logic [btf_pkg::REG_DATA_W-1:0]      csr_data
);

   logic             q_push;
   logic             q_full;
   logic             q_valid;
   logic             q_pop;
   btf_pkg::cmd_type q_item;
   btf_pkg::cmd_type q_head;
   btf_pkg::rsp_type rsp_item;

   assign req_full = q_full;

   // Front: registers, timer and target selection.
   btf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_cmd           (req_cmd),
      .req_now_seconds   (req_now_seconds),
      .req_second_pulse  (req_second_pulse),
      .req_supply_sample (req_supply_sample),
      .req_relay_auto_on (req_relay_auto_on),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (q_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Command queue between the two halves.
   btf_cmd_q u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_head),
      .pop       (q_pop)
   );

   // Back: level fading and result queue.
   btf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   assign rsp_backlight_duty   = rsp_item.backlight_duty;
   assign rsp_backlight_enable = rsp_item.backlight_enable;
   assign rsp_display_on       = rsp_item.display_on;
   assign rsp_contrast_duty    = rsp_item.contrast_duty;
   assign rsp_hold_ms          = rsp_item.hold_ms;
   assign rsp_still_fading     = rsp_item.still_fading;
   assign rsp_last             = rsp_item.last;

   // A non-final result is always the first half of a fall.
   a_first_half: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |->
         (rsp_hold_ms == btf_pkg::HOLD_HALF) && rsp_still_fading && rsp_backlight_enable)
      else $error("first half of a fall has wrong fields");

   // A dark backlight shows zero duty and turns the display off.
   a_off_dark: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_backlight_enable) |->
         (rsp_backlight_duty == 8'd0) && !rsp_display_on)
      else $error("backlight off but duty or display active");

   // The queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

### hdl/btf_cmd_q.sv
module btf_cmd_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  btf_pkg::cmd_type  push_item,
   output logic              full,
   output logic              valid,
   output btf_pkg::cmd_type  head,
   input  logic              pop
);

   btf_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   // Two-entry queue between the front and the back.
   assign full    = (count_ff == 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = 2'(count_ff + {1'b0, do_push} - {1'b0, do_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hdl/btf_front.sv
module btf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                req_cmd,
   input  logic [31:0]                         req_now_seconds,
   input  logic                                req_second_pulse,
   input  logic [9:0]                          req_supply_sample,
   input  logic                                req_relay_auto_on,
   input  logic                                q_full,
   output logic                                q_push,
   output btf_pkg::cmd_type                    q_item,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [btf_pkg::REG_INDEX_W-1:0]     csr_index,
   input  logic [btf_pkg::REG_DATA_W-1:0]      csr_data
);

   logic [4:0]  bright_ff, bright_in;
   logic [4:0]  dim_ff, dim_in;
   logic [7:0]  timeout_ff, timeout_in;
   logic        lock_ff, lock_in;
   logic [7:0]  stored_ff, stored_in;
   logic [9:0]  threshold_ff, threshold_in;
   logic [4:0]  target_ff, target_in;
   logic [31:0] last_act_ff, last_act_in;
   logic [7:0]  contrast_ff, contrast_in;

   logic        accept;
   logic        wr;
   logic [31:0] age;
   logic        expired;
   logic [4:0]  wr_level;
   logic [7:0]  wr_contrast;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign accept    = req_push & ~q_full;
   assign q_push    = accept;

   // Inactivity age, taken modulo 2^32.
   assign age     = req_now_seconds - last_act_ff;
   assign expired = (age >= {24'd0, timeout_ff});

   // Level write data saturated at the top level.
   assign wr_level = (csr_data[4:0] > btf_pkg::LEVEL_MAX) ? btf_pkg::LEVEL_MAX
                                                          : csr_data[4:0];
   assign wr_contrast = (csr_data[7:0] > 8'(btf_pkg::CONTRAST_TOP))
                        ? 8'd0 : 8'(8'(btf_pkg::CONTRAST_TOP) - csr_data[7:0]);

   // Register writes and item classification.
   always_comb begin
      bright_in    = bright_ff;
      dim_in       = dim_ff;
      timeout_in   = timeout_ff;
      lock_in      = lock_ff;
      stored_in    = stored_ff;
      threshold_in = threshold_ff;
      target_in    = target_ff;
      last_act_in  = last_act_ff;
      contrast_in  = contrast_ff;
      priority if (wr) begin
         unique case (csr_index)
            btf_pkg::REG_BRIGHT: begin
               bright_in = wr_level;
               if (dim_ff > wr_level) begin
                  dim_in = wr_level;
               end
            end
            btf_pkg::REG_DIM: begin
               dim_in = (wr_level > bright_ff) ? bright_ff : wr_level;
            end
            btf_pkg::REG_TIMEOUT:   timeout_in = csr_data[7:0];
            btf_pkg::REG_LOCK:      lock_in = csr_data[0];
            btf_pkg::REG_CONTRAST: begin
               stored_in   = wr_contrast;
               contrast_in = wr_contrast;
            end
            btf_pkg::REG_THRESHOLD: threshold_in = csr_data;
            default: ;
         endcase
      end else if (accept) begin
         if (req_cmd) begin
            // When unlocked, activity restarts the timer and aims at the bright level.
            if (!lock_ff) begin
               last_act_in = req_now_seconds;
               target_in   = bright_ff + 5'd1;
            end
         end else begin
            // A tick checks the supply on the second pulse, then, when unlocked, the timer.
            if (req_second_pulse) begin
               contrast_in = (req_supply_sample < threshold_ff) ? 8'd0 : stored_ff;
            end
            if (!lock_ff) begin
               if (expired) begin
                  target_in = req_relay_auto_on ? 5'(dim_ff + 5'd1) : btf_pkg::CODE_OFF;
               end else begin
                  target_in = bright_ff + 5'd1;
               end
            end
         end
      end else begin
         // No write and no item: every register keeps its value.
      end
   end

   // The command carries the updated target and contrast and the current lock.
   always_comb begin
      q_item.target   = target_in;
      q_item.lock     = lock_ff;
      q_item.contrast = contrast_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff    <= btf_pkg::BRIGHT_RESET;
         dim_ff       <= btf_pkg::DIM_RESET;
         timeout_ff   <= btf_pkg::TIMEOUT_RESET;
         lock_ff      <= 1'b0;
         stored_ff    <= btf_pkg::CONTRAST_RESET;
         threshold_ff <= btf_pkg::THRESHOLD_RESET;
         target_ff    <= btf_pkg::LEVEL_CODE_RESET;
         last_act_ff  <= 32'd0;
         contrast_ff  <= btf_pkg::CONTRAST_RESET;
      end else begin
         bright_ff    <= bright_in;
         dim_ff       <= dim_in;
         timeout_ff   <= timeout_in;
         lock_ff      <= lock_in;
         stored_ff    <= stored_in;
         threshold_ff <= threshold_in;
         target_ff    <= target_in;
         last_act_ff  <= last_act_in;
         contrast_ff  <= contrast_in;
      end
   end

endmodule

### hdl/btf_back.sv
module btf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  btf_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output btf_pkg::rsp_type  rsp_item
);

   logic [4:0] level_ff, level_in;
   logic       phase_ff, phase_in;

   btf_pkg::rsp_type oq_mem_ff [2];
   logic       oq_wr_ff, oq_wr_in;
   logic       oq_rd_ff, oq_rd_in;
   logic [1:0] oq_count_ff, oq_count_in;
   logic       oq_pop;
   logic       space;
   logic       res_push;
   btf_pkg::rsp_type res;
   logic [4:0] lower;

   assign oq_pop    = rsp_pop & (oq_count_ff != 2'd0);
   assign space     = (oq_count_ff != 2'd2) | oq_pop;
   assign lower     = level_ff - 5'd1;
   assign rsp_empty = (oq_count_ff == 2'd0);
   assign rsp_item  = oq_mem_ff[oq_rd_ff];

   // Fade step: one result per cycle while a command waits and results have room; a fall above four gives two.
   always_comb begin
      level_in = level_ff;
      phase_in = phase_ff;
      cmd_pop  = 1'b0;
      res_push = 1'b0;
      res.backlight_duty   = btf_pkg::level_duty(level_ff);
      res.backlight_enable = (level_ff != btf_pkg::CODE_OFF);
      res.display_on       = (level_ff != btf_pkg::CODE_OFF);
      res.contrast_duty    = cmd.contrast;
      res.hold_ms          = btf_pkg::HOLD_NONE;
      res.still_fading     = (cmd.target != level_ff);
      res.last             = 1'b1;
      if (cmd_valid && space) begin
         res_push = 1'b1;
         priority if (cmd.lock) begin
            cmd_pop = 1'b1;
         end else if (cmd.target < level_ff) begin
            if (level_ff > btf_pkg::CODE_FOUR) begin
               if (!phase_ff) begin
                  // First half of the fall shows the halfway duty.
                  res.backlight_duty = btf_pkg::half_duty(level_ff);
                  res.hold_ms        = btf_pkg::HOLD_HALF;
                  res.still_fading   = 1'b1;
                  res.last           = 1'b0;
                  phase_in           = 1'b1;
               end else begin
                  level_in             = lower;
                  phase_in             = 1'b0;
                  cmd_pop              = 1'b1;
                  res.backlight_duty   = btf_pkg::level_duty(lower);
                  res.backlight_enable = (lower != btf_pkg::CODE_OFF);
                  res.display_on       = (lower != btf_pkg::CODE_OFF);
                  res.hold_ms          = btf_pkg::HOLD_HALF;
                  res.still_fading     = (cmd.target != lower);
               end
            end else begin
               level_in             = lower;
               cmd_pop              = 1'b1;
               res.backlight_duty   = btf_pkg::level_duty(lower);
               res.backlight_enable = (lower != btf_pkg::CODE_OFF);
               res.display_on       = (lower != btf_pkg::CODE_OFF);
               res.hold_ms          = btf_pkg::HOLD_FULL;
               res.still_fading     = (cmd.target != lower);
            end
         end else begin
            // Steady or rising: jump to the target.
            level_in             = cmd.target;
            cmd_pop              = 1'b1;
            res.backlight_duty   = btf_pkg::level_duty(cmd.target);
            res.backlight_enable = (cmd.target != btf_pkg::CODE_OFF);
            res.display_on       = (cmd.target != btf_pkg::CODE_OFF);
            res.still_fading     = 1'b0;
         end
      end
   end

   // Result queue pointers.
   always_comb begin
      oq_wr_in    = oq_wr_ff ^ res_push;
      oq_rd_in    = oq_rd_ff ^ oq_pop;
      oq_count_in = 2'(oq_count_ff + {1'b0, res_push} - {1'b0, oq_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff    <= btf_pkg::LEVEL_CODE_RESET;
         phase_ff    <= 1'b0;
         oq_wr_ff    <= 1'b0;
         oq_rd_ff    <= 1'b0;
         oq_count_ff <= 2'd0;
      end else begin
         level_ff    <= level_in;
         phase_ff    <= phase_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         oq_mem_ff[oq_wr_ff] <= res;
      end
   end

endmodule

### bench/btf_checker.sv
`timescale 1ns / 100ps
module btf_checker
   import btf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic                   req_full,
   input  logic                   req_cmd,
   input  logic [31:0]            req_now_seconds,
   input  logic                   req_second_pulse,
   input  logic [9:0]             req_supply_sample,
   input  logic                   req_relay_auto_on,
   input  logic                   rsp_empty,
   input  logic                   rsp_pop,
   input  logic [7:0]             rsp_backlight_duty,
   input  logic                   rsp_backlight_enable,
   input  logic                   rsp_display_on,
   input  logic [7:0]             rsp_contrast_duty,
   input  logic [5:0]             rsp_hold_ms,
   input  logic                   rsp_still_fading,
   input  logic                   rsp_last,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [REG_INDEX_W-1:0] csr_index,
   input  logic [REG_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     outstanding,
   output int                     results_checked,
   output int                     split_fades
);

   // Levels run from off (-1) to the top of the duty scale.
   localparam int LEVEL_OFF         = -1;
   localparam int LEVEL_TOP         = 16;
   localparam int LEVEL_SPLIT_FLOOR = 4;
   localparam int PRINT_LIMIT       = 40;

   // Settings as the register port left them.
   logic [4:0] bright_cfg;
   logic [4:0] dim_cfg;
   logic [7:0] timeout_cfg;
   logic       lock_cfg;
   logic [7:0] contrast_base;
   logic [9:0] threshold_cfg;

   // Fader state.
   int          level_shown;
   int          level_goal;
   logic [31:0] activity_stamp;
   logic [7:0]  contrast_now;

   // Results predicted but not yet popped, oldest first.
   rsp_type due_results[$];

   // Duty of a level; off reads as zero.
   function automatic logic [7:0] duty_of_level(input int lv);
      logic [7:0] d;
      case (lv)
         0:  d = 8'd0;
         1:  d = 8'd1;
         2:  d = 8'd2;
         3:  d = 8'd3;
         4:  d = 8'd4;
         5:  d = 8'd8;
         6:  d = 8'd13;
         7:  d = 8'd21;
         8:  d = 8'd32;
         9:  d = 8'd45;
         10: d = 8'd62;
         11: d = 8'd83;
         12: d = 8'd108;
         13: d = 8'd137;
         14: d = 8'd171;
         15: d = 8'd210;
         16: d = 8'd255;
         default: d = (lv < 0) ? 8'd0 : 8'd255;
      endcase
      return d;
   endfunction

   function automatic void add_expected(input logic [7:0] duty, input int lv,
                                        input logic [5:0] hold, input logic fading,
                                        input logic is_last);
      rsp_type r;
      r.backlight_duty   = duty;
      r.backlight_enable = (lv >= 0);
      r.display_on       = (lv >= 0);
      r.contrast_duty    = contrast_now;
      r.hold_ms          = hold;
      r.still_fading     = fading;
      r.last             = is_last;
      due_results.push_back(r);
   endfunction

   // Show the present level unchanged, as a locked fader does.
   function automatic void hold_present_level();
      add_expected(duty_of_level(level_shown), level_shown, HOLD_NONE,
                   level_goal != level_shown, 1'b1);
   endfunction

   // One fade step: rises jump to the goal, falls move one level per item.
   function automatic void step_toward_goal();
      int         lower;
      int         hi;
      int         lo;
      logic [7:0] half;
      if (level_goal < level_shown) begin
         lower = level_shown - 1;
         if (level_shown > LEVEL_SPLIT_FLOOR) begin
            // Above level four the fall shows a halfway duty first.
            hi   = int'(duty_of_level(level_shown));
            lo   = int'(duty_of_level(lower));
            half = 8'((hi - lo) / 2 + lo);
            add_expected(half, level_shown, HOLD_HALF, 1'b1, 1'b0);
            level_shown = lower;
            add_expected(duty_of_level(level_shown), level_shown, HOLD_HALF,
                         level_goal != level_shown, 1'b1);
            split_fades++;
         end else begin
            level_shown = lower;
            add_expected(duty_of_level(level_shown), level_shown, HOLD_FULL,
                         level_goal != level_shown, 1'b1);
         end
      end else begin
         if (level_goal > level_shown)
            level_shown = level_goal;
         add_expected(duty_of_level(level_shown), level_shown, HOLD_NONE,
                      level_goal != level_shown, 1'b1);
      end
   endfunction

   // Work out the results of one accepted item.
   function automatic void predict_fader_step(input logic activity,
                                              input logic [31:0] stamp,
                                              input logic pulse,
                                              input logic [9:0] sample,
                                              input logic relay_on);
      logic [31:0] elapsed;
      if (activity) begin
         if (lock_cfg) begin
            hold_present_level();
         end else begin
            activity_stamp = stamp;
            level_goal     = int'(bright_cfg);
            step_toward_goal();
         end
      end else begin
         // The supply check only runs on the 1 Hz tick.
         if (pulse)
            contrast_now = (sample < threshold_cfg) ? 8'd0 : contrast_base;
         if (lock_cfg) begin
            hold_present_level();
         end else begin
            elapsed = stamp - activity_stamp;
            if (elapsed >= 32'(timeout_cfg))
               level_goal = relay_on ? int'(dim_cfg) : LEVEL_OFF;
            else
               level_goal = int'(bright_cfg);
            step_toward_goal();
         end
      end
   endfunction

   // Register write with the clamping that each register applies.
   function automatic void write_register(input logic [REG_INDEX_W-1:0] idx,
                                          input logic [REG_DATA_W-1:0] data);
      int v;
      case (idx)
         REG_BRIGHT: begin
            v = int'(data[4:0]);
            if (v > LEVEL_TOP)
               v = LEVEL_TOP;
            bright_cfg = 5'(v);
            if (dim_cfg > bright_cfg)
               dim_cfg = bright_cfg;
         end
         REG_DIM: begin
            v = int'(data[4:0]);
            if (v > LEVEL_TOP)
               v = LEVEL_TOP;
            if (v > int'(bright_cfg))
               v = int'(bright_cfg);
            dim_cfg = 5'(v);
         end
         REG_TIMEOUT:   timeout_cfg = data[7:0];
         REG_LOCK:      lock_cfg = data[0];
         REG_CONTRAST: begin
            v = int'(data[7:0]);
            if (v > int'(CONTRAST_TOP))
               v = int'(CONTRAST_TOP);
            contrast_base = 8'(int'(CONTRAST_TOP) - v);
            contrast_now  = contrast_base;
         end
         REG_THRESHOLD: threshold_cfg = data[9:0];
         default: ;
      endcase
   endfunction

   function automatic void reset_model();
      bright_cfg     = BRIGHT_RESET;
      dim_cfg        = DIM_RESET;
      timeout_cfg    = TIMEOUT_RESET;
      lock_cfg       = 1'b0;
      contrast_base  = CONTRAST_RESET;
      threshold_cfg  = THRESHOLD_RESET;
      level_shown    = int'(BRIGHT_RESET);
      level_goal     = int'(BRIGHT_RESET);
      activity_stamp = '0;
      contrast_now   = CONTRAST_RESET;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("ERROR %0t ns: %s", $realtime, what);
   endtask

   task automatic report_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
      report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                results_checked, name, got, want));
   endtask

   // Compare a popped result with the oldest prediction.
   task automatic check_result();
      rsp_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("result with none pending: duty %0d hold %0d last %0d",
                                   rsp_backlight_duty, rsp_hold_ms, rsp_last));
         return;
      end
      want = due_results.pop_front();
      results_checked++;
      if (rsp_backlight_duty !== want.backlight_duty)
         report_field("backlight_duty", rsp_backlight_duty, want.backlight_duty);
      if (rsp_backlight_enable !== want.backlight_enable)
         report_field("backlight_enable", 8'(rsp_backlight_enable),
                      8'(want.backlight_enable));
      if (rsp_display_on !== want.display_on)
         report_field("display_on", 8'(rsp_display_on), 8'(want.display_on));
      if (rsp_contrast_duty !== want.contrast_duty)
         report_field("contrast_duty", rsp_contrast_duty, want.contrast_duty);
      if (rsp_hold_ms !== want.hold_ms)
         report_field("hold_ms", 8'(rsp_hold_ms), 8'(want.hold_ms));
      if (rsp_still_fading !== want.still_fading)
         report_field("still_fading", 8'(rsp_still_fading), 8'(want.still_fading));
      if (rsp_last !== want.last)
         report_field("last", 8'(rsp_last), 8'(want.last));
   endtask

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         due_results.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result();
         if (csr_valid && csr_ready)
            write_register(csr_index, csr_data);
         if (req_push && !req_full)
            predict_fader_step(req_cmd, req_now_seconds, req_second_pulse,
                               req_supply_sample, req_relay_auto_on);
      end
      outstanding <= due_results.size();
   end

endmodule

### bench/tb_backlight_timeout_fader.sv
`timescale 1ns / 100ps
module tb_backlight_timeout_fader;
   import btf_pkg::*;

   localparam logic CMD_TICK     = 1'b0;
   localparam logic CMD_ACTIVITY = 1'b1;

   localparam logic [REG_INDEX_W-1:0] REG_UNUSED_LO = REG_THRESHOLD + 3'd1;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_SETUPS   = 12;
   localparam int ITEMS_PER_SETUP = 160;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 16;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic                   req_cmd = 1'b0;
   logic [31:0]            req_now_seconds = '0;
   logic                   req_second_pulse = 1'b0;
   logic [9:0]             req_supply_sample = '0;
   logic                   req_relay_auto_on = 1'b0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [7:0]             rsp_backlight_duty;
   logic                   rsp_backlight_enable;
   logic                   rsp_display_on;
   logic [7:0]             rsp_contrast_duty;
   logic [5:0]             rsp_hold_ms;
   logic                   rsp_still_fading;
   logic                   rsp_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [REG_INDEX_W-1:0] csr_index = '0;
   logic [REG_DATA_W-1:0]  csr_data = '0;

   int mismatches;
   int outstanding;
   int results_checked;
   int split_fades;

   int          cycle_count = 0;
   int          items_sent = 0;
   int          activity_sent = 0;
   int          writes_done = 0;
   int          setups_done = 0;
   logic [31:0] seconds_now = '0;
   logic        relay_state = 1'b0;
   logic [9:0]  threshold_set = THRESHOLD_RESET;
   logic        steady_sender = 1'b0;

   backlight_timeout_fader dut (.*);

   btf_checker fader_check (.*);

   always #2 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending.",
                  cycle_count, outstanding);
         $display("** backlight_timeout_fader: FAILED **");
         $finish;
      end
   end

   // Result side: bursts of pops broken by stalls, mostly short.
   initial begin
      int   r;
      int   span;
      logic level;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            level = 1'b1;
            span  = $urandom_range(1, 30);
         end else begin
            level = 1'b0;
            if (r < 85)
               span = $urandom_range(1, 3);
            else if (r < 97)
               span = $urandom_range(4, 10);
            else
               span = $urandom_range(20, 60);
         end
         repeat (span) begin
            @(negedge clock);
            rsp_pop <= level;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   // Supply readings cluster around the threshold so both sides are hit.
   function automatic logic [9:0] pick_sample();
      int r;
      int s;
      r = $urandom_range(0, 9);
      if (r == 0)
         return 10'd0;
      if (r == 1)
         return 10'h3FF;
      if (r < 6) begin
         s = int'(threshold_set) + $urandom_range(0, 8) - 4;
         if (s < 0)
            s = 0;
         if (s > 1023)
            s = 1023;
         return 10'(s);
      end
      return 10'($urandom_range(0, 1023));
   endfunction

   // Level data with random bits above the five the register keeps.
   function automatic logic [REG_DATA_W-1:0] pick_level_data();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r == 0)
         v = 0;
      else if (r == 1)
         v = 16;
      else if (r == 2)
         v = 31;
      else
         v = $urandom_range(0, 16);
      return {5'($urandom), 5'(v)};
   endfunction

   function automatic logic [7:0] pick_byte_extreme();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0)
         return 8'd0;
      if (r == 1)
         return 8'd255;
      return 8'($urandom);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic send_item(input logic cmd, input logic [31:0] stamp,
                            input logic pulse, input logic [9:0] sample,
                            input logic relay_on);
      int gap;
      gap = steady_sender ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push          <= 1'b1;
      req_cmd           <= cmd;
      req_now_seconds   <= stamp;
      req_second_pulse  <= pulse;
      req_supply_sample <= sample;
      req_relay_auto_on <= relay_on;
      do @(posedge clock); while (req_full !== 1'b0);
      items_sent++;
      if (cmd == CMD_ACTIVITY)
         activity_sent++;
   endtask

   task automatic tick(input logic [31:0] advance, input logic relay_on);
      seconds_now = seconds_now + advance;
      send_item(CMD_TICK, seconds_now, advance != 0, pick_sample(), relay_on);
   endtask

   task automatic write_reg(input logic [REG_INDEX_W-1:0] idx,
                            input logic [REG_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      writes_done++;
      if (idx == REG_THRESHOLD)
         threshold_set = data;
   endtask

   task automatic release_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering items and let every expected result drain.
   task automatic quiesce();
      @(negedge clock);
      req_push <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Write every register once, in a random order, with random extremes, and sometimes an unused index.
   task automatic apply_setup();
      logic [REG_DATA_W-1:0]  value [0:7];
      logic [REG_INDEX_W-1:0] order[$];
      logic [REG_INDEX_W-1:0] swap;
      int                     j;
      value[REG_BRIGHT]    = pick_level_data();
      value[REG_DIM]       = pick_level_data();
      value[REG_TIMEOUT]   = {2'($urandom), 8'($urandom_range(0, 5) < 3 ?
                                            $urandom_range(0, 40) : pick_byte_extreme())};
      value[REG_LOCK]      = {9'($urandom), 1'($urandom_range(0, 6) == 0)};
      value[REG_CONTRAST]  = {2'($urandom), pick_byte_extreme()};
      value[REG_THRESHOLD] = ($urandom_range(0, 4) == 0) ?
                             (($urandom_range(0, 1) == 0) ? 10'd0 : 10'h3FF) : 10'($urandom);
      value[REG_UNUSED_LO]        = 10'($urandom);
      value[REG_UNUSED_LO + 3'd1] = 10'($urandom);
      order = '{REG_BRIGHT, REG_DIM, REG_TIMEOUT, REG_LOCK, REG_CONTRAST, REG_THRESHOLD};
      if ($urandom_range(0, 3) == 0)
         order.push_back(REG_UNUSED_LO + 3'($urandom_range(0, 1)));
      for (int k = order.size() - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         swap     = order[k];
         order[k] = order[j];
         order[j] = swap;
      end
      foreach (order[k])
         write_reg(order[k], value[order[k]]);
      release_csr();
      setups_done++;
   endtask

   // Mostly a running seconds count with ticks, some user activity,
   // jumps past the timeout, and a share of fully random items.
   task automatic run_traffic(input int count);
      int          r;
      logic [31:0] advance;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 29) == 0)
            relay_state = ~relay_state;
         if (r < 10) begin
            send_item(CMD_ACTIVITY, seconds_now, 1'($urandom), pick_sample(), relay_state);
         end else if (r < 15) begin
            send_item(1'($urandom), $urandom, 1'($urandom), 10'($urandom), 1'($urandom));
         end else if (r < 19) begin
            advance = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(30, 400);
            tick(advance, relay_state);
         end else begin
            advance = ($urandom_range(0, 2) == 0) ? 32'd1 : 32'd0;
            tick(advance, relay_state);
         end
      end
   endtask

   initial begin
      int r;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: steady, the supply check on and off a pulse,
      // and a pulse on an activity event that must be ignored.
      send_item(CMD_TICK, 32'd0, 1'b1, 10'h3FF, 1'b1);
      send_item(CMD_TICK, 32'd1, 1'b1, 10'd0, 1'b1);
      send_item(CMD_TICK, 32'd2, 1'b1, 10'd700, 1'b1);
      send_item(CMD_TICK, 32'd2, 1'b0, 10'd0, 1'b1);
      send_item(CMD_ACTIVITY, 32'd3, 1'b1, 10'd0, 1'b1);

      // Timeout with the relay on aims at dim; then off, falling through
      // the halfway steps, the plain steps at four and below, and off.
      send_item(CMD_TICK, 32'd40, 1'b1, 10'd800, 1'b1);
      repeat (15)
         send_item(CMD_TICK, 32'd41, 1'b0, 10'd800, 1'b0);

      // Activity rises at once; the elapsed time is taken across the wrap.
      send_item(CMD_ACTIVITY, 32'hFFFF_FFF0, 1'b0, 10'd800, 1'b0);
      send_item(CMD_TICK, 32'h0000_0005, 1'b1, 10'd800, 1'b0);
      quiesce();

      // Locked: activity and timeout are ignored, contrast still updates.
      write_reg(REG_LOCK, 10'd1);
      release_csr();
      send_item(CMD_ACTIVITY, 32'h0000_0100, 1'b0, 10'd800, 1'b1);
      send_item(CMD_TICK, 32'h0000_1000, 1'b1, 10'd0, 1'b0);
      quiesce();

      // Top of every register, junk in unused bits, unused indexes.
      write_reg(REG_BRIGHT, 10'h3FF);
      write_reg(REG_DIM, 10'h3FF);
      write_reg(REG_TIMEOUT, 10'h300);
      write_reg(REG_LOCK, 10'h3FE);
      write_reg(REG_CONTRAST, 10'h3FF);
      write_reg(REG_THRESHOLD, 10'h3FF);
      write_reg(REG_UNUSED_LO, 10'h2AA);
      write_reg(REG_UNUSED_LO + 3'd1, 10'h155);
      release_csr();
      send_item(CMD_TICK, 32'h0000_1000, 1'b1, 10'h3FE, 1'b1);
      send_item(CMD_TICK, 32'h0000_1000, 1'b1, 10'h3FF, 1'b0);
      quiesce();

      // Bottom: a zero bright level drags the dim level down with it.
      write_reg(REG_BRIGHT, 10'd0);
      write_reg(REG_CONTRAST, 10'd0);
      write_reg(REG_THRESHOLD, 10'd0);
      write_reg(REG_TIMEOUT, 10'd255);
      release_csr();
      send_item(CMD_ACTIVITY, 32'h0000_2000, 1'b0, 10'd0, 1'b1);
      send_item(CMD_TICK, 32'h0000_20FF, 1'b1, 10'd0, 1'b1);
      send_item(CMD_TICK, 32'h0000_20FE, 1'b1, 10'd0, 1'b1);
      quiesce();

      // Random setups, each followed by a stretch of traffic.
      for (int s = 0; s < RANDOM_SETUPS; s++) begin
         apply_setup();
         r = $urandom_range(0, 3);
         if (r == 0)
            seconds_now = $urandom_range(0, 50);
         else if (r == 1)
            seconds_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
         else
            seconds_now = $urandom;
         relay_state   = 1'($urandom);
         steady_sender = ($urandom_range(0, 3) == 0);
         run_traffic(ITEMS_PER_SETUP);
         quiesce();
      end

      steady_sender = 1'b0;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d items (%0d user activity) and %0d register writes over %0d setups.",
               items_sent, activity_sent, writes_done, setups_done + 4);
      $display("Checked %0d results, %0d halfway fades among them.",
               results_checked, split_fades);
      if (mismatches == 0)
         $display("** backlight_timeout_fader: PASSED **");
      else
         $display("** backlight_timeout_fader: FAILED **");
      $finish;
   end

endmodule

### filelist.f
hdl/btf_pkg.sv
hdl/btf_cmd_q.sv
hdl/btf_front.sv
hdl/btf_back.sv
hdl/backlight_timeout_fader.sv
bench/btf_checker.sv
bench/tb_backlight_timeout_fader.sv
